### design/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, sizes and codes for the counting barrier table.
// ----------------------------------------------------------------------------
package bst_pkg;

   localparam int BARRIERS  = 16;
   localparam int WAITERS   = 32;
   localparam int CLIENTS   = 1024;

   localparam int CMD_W     = 2;
   localparam int BID_W     = 4;
   localparam int CLI_W     = 10;
   localparam int ICNT_W    = 12;
   localparam int ERR_W     = 8;
   localparam int CNT_W     = 14;
   localparam int CONTRIB_W = 13;

   localparam int BAR_W     = (BARRIERS > 1) ? $clog2(BARRIERS) : 1;
   localparam int MAP_W     = $clog2(BARRIERS + 1);
   localparam int FILL_W    = $clog2(WAITERS + 1);
   localparam int WADDR_W   = $clog2(BARRIERS * WAITERS);
   localparam int CADDR_W   = $clog2(CLIENTS);

   localparam logic [CMD_W-1:0] CMD_INIT       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WAIT       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd3;

   localparam logic [ERR_W-1:0] HANGUP_RESET_CODE = 8'd255;
   localparam logic [MAP_W-1:0] MAP_NONE = MAP_W'(BARRIERS);

   localparam logic [1:0] CSR_HANGUP_ADDR = 2'd0;

   typedef enum logic [1:0] {
      OP_BARRIER_INIT,
      OP_BARRIER_WAIT,
      OP_DISCONNECT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BID_W-1:0]  barrier_id;
      logic [CLI_W-1:0]  client_id;
      logic              stream_client;
      logic [ICNT_W-1:0] init_count;
      logic              no_wait;
      logic [ERR_W-1:0]  error_code;
   } req_type;

   typedef struct packed {
      logic [CLI_W-1:0] client_id_res;
      logic             stream_client_res;
      logic [ERR_W-1:0] result_code;
      logic             rejected;
      logic             last;
   } rsp_type;

   // classified transaction handed from the front to the engine
   typedef struct packed {
      op_type            op;
      logic [BAR_W-1:0]  barrier;
      logic [CLI_W-1:0]  client;
      logic              stream;
      logic [ICNT_W-1:0] count;
      logic              record;
      logic [ERR_W-1:0]  err;
   } op_item_type;

   typedef struct packed {
      logic [CLI_W-1:0]     client;
      logic                 stream;
      logic [CONTRIB_W-1:0] contrib;
   } waiter_type;

   typedef enum logic [3:0] {
      ST_MAP_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_REL_RD,
      ST_REL_OUT,
      ST_MAP_RD,
      ST_MAP_CHK,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SH_RD,
      ST_SH_WR
   } eng_state_type;

endpackage

### design/barrier_sync_table.sv
// ----------------------------------------------------------------------------
// barrier_sync_table
// Table of counting barriers with waiter lists, release and disconnect.
// ----------------------------------------------------------------------------
// A request passes the front queue and the engine's item register before its
// result enters the result queue; a release reads each waiter in turn and then
// frees the barrier. The engine takes a new request only once it is back in
// idle; a disconnect reads the client map, searches the list, shifts entries down.
// Reset: the client map is swept to "no barrier", one entry per cycle, over
// all CLIENTS (1024) entries; requests queue but are not executed meanwhile.
// ----------------------------------------------------------------------------
module barrier_sync_table import bst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [ERR_W-1:0] hangup_ff;
   logic             q_valid, q_pop;
   op_item_type      q_data;
   logic             fifo_push, fifo_full;
   rsp_type          fifo_data;

   // hold the hangup code; writes land in the access phase
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_HANGUP_ADDR) ? 32'(hangup_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hangup_ff <= HANGUP_RESET_CODE;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == CSR_HANGUP_ADDR) begin
         hangup_ff <= csr_pwdata[ERR_W-1:0];
      end
   end

   // front: accept and classify each request transaction
   bst_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop)
   );

   // back: barrier state, waiter lists and client map
   bst_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .hangup_code (hangup_ff),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_full    (fifo_full),
      .rsp_push    (fifo_push),
      .rsp_data    (fifo_data)
   );

   // result queue parts the engine from the consumer
   bst_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_data),
      .full      (fifo_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

endmodule

### design/bst_front.sv
// ----------------------------------------------------------------------------
// bst_front
// Accepts request transactions, classifies them and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
module bst_front import bst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        q_valid,
   output op_item_type q_data,
   input  logic        q_pop
);

   op_item_type ent_ff [2];
   logic        wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   op_item_type cls;
   logic        drop, enq;

   always_comb begin
      unique case (req_data.cmd)
         CMD_INIT:       cls.op = OP_BARRIER_INIT;
         CMD_WAIT:       cls.op = OP_BARRIER_WAIT;
         CMD_DISCONNECT: cls.op = OP_DISCONNECT;
         default:        cls.op = OP_CLEAR;
      endcase
      cls.barrier = BAR_W'(req_data.barrier_id);
      cls.client  = req_data.client_id;
      cls.stream  = req_data.stream_client;
      cls.count   = req_data.init_count;
      cls.record  = !(req_data.cmd == CMD_INIT && req_data.no_wait);
      cls.err     = req_data.error_code;
      // drop barrier indexes beyond the table
      drop = (req_data.cmd != CMD_DISCONNECT) && (int'(req_data.barrier_id) >= BARRIERS);
   end

   assign req_full = (cnt_ff == 2'd2);
   assign enq      = req_push && !req_full && !drop;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = ent_ff[rd_ff];

   always_comb begin
      wr_in  = enq ? !wr_ff : wr_ff;
      rd_in  = (q_pop && q_valid) ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(enq) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (enq) begin
         ent_ff[wr_ff] <= cls;
      end
   end

endmodule

### design/bst_rsp_fifo.sv
// ----------------------------------------------------------------------------
// bst_rsp_fifo
// Four-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module bst_rsp_fifo import bst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type pop_data
);

   rsp_type    mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 3'd4);
   assign empty    = (cnt_ff == 3'd0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign cnt_in   = cnt_ff + 3'(do_push) - 3'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 2'd1;
         if (do_pop)  rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### design/bst_engine.sv
// ----------------------------------------------------------------------------
// bst_engine
// Carries out classified transactions: barrier state update, waiter list
// release, disconnect search and list compaction.
// ----------------------------------------------------------------------------
module bst_engine import bst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [ERR_W-1:0] hangup_code,
   input  logic             q_valid,
   input  op_item_type      q_data,
   output logic             q_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output rsp_type          rsp_data
);

   function automatic logic [WADDR_W-1:0] waddr(input logic [BAR_W-1:0] b,
                                                input logic [FILL_W-1:0] i);
      return WADDR_W'(int'(b) * WAITERS + int'(i));
   endfunction

   eng_state_type       state_ff, state_in;
   op_item_type         item_ff;
   logic [FILL_W-1:0]   idx_ff, idx_in, lim_ff, lim_in;
   logic [ERR_W-1:0]    code_ff, code_in;
   logic [BAR_W-1:0]    bar_ff, bar_in;
   logic [CADDR_W-1:0]  init_ff, init_in;

   logic                valid_ff [BARRIERS];
   logic [CNT_W-1:0]    count_ff [BARRIERS];
   logic [ERR_W-1:0]    maxe_ff  [BARRIERS];
   logic [FILL_W-1:0]   fill_ff  [BARRIERS];

   waiter_type          wmem [BARRIERS*WAITERS];
   logic [MAP_W-1:0]    mmem [CLIENTS];
   waiter_type          wrd_ff;
   logic [MAP_W-1:0]    mrd_ff;

   logic                w_re, w_we, m_re, m_we, b_we;
   logic [WADDR_W-1:0]  w_raddr, w_waddr;
   waiter_type          w_wdata;
   logic [CADDR_W-1:0]  m_raddr, m_waddr;
   logic [MAP_W-1:0]    m_wdata;
   logic [BAR_W-1:0]    b_wsel;
   logic                b_valid_in;
   logic [CNT_W-1:0]    b_count_in;
   logic [ERR_W-1:0]    b_maxe_in;
   logic [FILL_W-1:0]   b_fill_in;

   logic [BAR_W-1:0]    cb, mbb;
   logic                c_valid, ex_full, client_ok, mb_ok, hit;
   logic [FILL_W-1:0]   ef, nf, idx_nx;
   logic [CNT_W-1:0]    ec, nc;
   logic [ERR_W-1:0]    em, nm;

   // shared conditions
   always_comb begin
      cb        = item_ff.barrier;
      c_valid   = valid_ff[cb];
      ef        = c_valid ? fill_ff[cb]  : '0;
      ec        = c_valid ? count_ff[cb] : '0;
      em        = c_valid ? maxe_ff[cb]  : '0;
      ex_full   = item_ff.record && (int'(ef) >= WAITERS);
      nc        = (item_ff.op == OP_BARRIER_INIT) ? ec + CNT_W'(item_ff.count)
                                                  : ec - CNT_W'(1);
      nf        = item_ff.record ? ef + FILL_W'(1) : ef;
      nm        = (item_ff.record && item_ff.err > em) ? item_ff.err : em;
      client_ok = int'(item_ff.client) < CLIENTS;
      mbb       = mrd_ff[BAR_W-1:0];
      mb_ok     = (int'(mrd_ff) < BARRIERS) && valid_ff[mbb] && (fill_ff[mbb] != '0);
      hit       = wrd_ff.stream && (wrd_ff.client == item_ff.client);
      idx_nx    = idx_ff + FILL_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_MAP_INIT: if (int'(init_ff) == CLIENTS - 1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (q_valid) state_in = (q_data.op == OP_DISCONNECT) ? ST_MAP_RD : ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_full) begin
               if (item_ff.op == OP_CLEAR)  state_in = c_valid ? ST_REL_RD : ST_IDLE;
               else if (ex_full)            state_in = ST_IDLE;
               else                         state_in = (nc == '0) ? ST_REL_RD : ST_IDLE;
            end
         end
         ST_REL_RD:   state_in = (idx_ff == lim_ff) ? ST_IDLE : ST_REL_OUT;
         ST_REL_OUT:  if (!rsp_full) state_in = ST_REL_RD;
         ST_MAP_RD:   state_in = client_ok ? ST_MAP_CHK : ST_IDLE;
         ST_MAP_CHK:  state_in = mb_ok ? ST_SRCH_RD : ST_IDLE;
         ST_SRCH_RD:  state_in = ST_SRCH_CHK;
         ST_SRCH_CHK: begin
            if (hit)                   state_in = ST_SH_RD;
            else if (idx_nx == lim_ff) state_in = ST_IDLE;
            else                       state_in = ST_SRCH_RD;
         end
         ST_SH_RD:    state_in = (idx_nx >= lim_ff) ? ST_IDLE : ST_SH_WR;
         ST_SH_WR:    state_in = ST_SH_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      q_pop      = 1'b0;
      rsp_push   = 1'b0;
      rsp_data   = '0;
      w_re       = 1'b0;
      w_raddr    = '0;
      w_we       = 1'b0;
      w_waddr    = '0;
      w_wdata    = wrd_ff;
      m_re       = 1'b0;
      m_raddr    = CADDR_W'(item_ff.client);
      m_we       = 1'b0;
      m_waddr    = CADDR_W'(item_ff.client);
      m_wdata    = MAP_NONE;
      b_we       = 1'b0;
      b_wsel     = bar_ff;
      b_valid_in = 1'b0;
      b_count_in = '0;
      b_maxe_in  = '0;
      b_fill_in  = '0;
      idx_in     = idx_ff;
      lim_in     = lim_ff;
      code_in    = code_ff;
      bar_in     = bar_ff;
      init_in    = init_ff;
      unique case (state_ff)
         ST_MAP_INIT: begin
            m_we    = 1'b1;
            m_waddr = init_ff;
            init_in = init_ff + CADDR_W'(1);
         end
         ST_IDLE: q_pop = q_valid;
         ST_EXEC: begin
            if (!rsp_full) begin
               if (item_ff.op == OP_CLEAR) begin
                  code_in = hangup_code;
                  lim_in  = ef;
                  idx_in  = '0;
                  bar_in  = cb;
               end else if (ex_full) begin
                  rsp_push = 1'b1;
                  rsp_data = '{client_id_res: item_ff.client,
                               stream_client_res: item_ff.stream,
                               result_code: '0, rejected: 1'b1, last: 1'b1};
               end else begin
                  if (!item_ff.record) begin
                     rsp_push = 1'b1;
                     rsp_data = '{client_id_res: item_ff.client,
                                  stream_client_res: item_ff.stream,
                                  result_code: '0, rejected: 1'b0,
                                  last: (nc != '0) || (ef == '0)};
                     m_we = item_ff.stream && client_ok;
                  end else begin
                     w_we    = 1'b1;
                     w_waddr = waddr(cb, ef);
                     w_wdata.client  = item_ff.client;
                     w_wdata.stream  = item_ff.stream;
                     w_wdata.contrib = (item_ff.op == OP_BARRIER_INIT)
                                       ? CONTRIB_W'(item_ff.count) : '1;
                     m_we    = item_ff.stream && client_ok;
                     m_wdata = MAP_W'(cb);
                  end
                  b_we       = 1'b1;
                  b_wsel     = cb;
                  b_valid_in = 1'b1;
                  b_count_in = nc;
                  b_maxe_in  = nm;
                  b_fill_in  = nf;
                  lim_in     = nf;
                  idx_in     = '0;
                  code_in    = nm;
                  bar_in     = cb;
               end
            end
         end
         ST_REL_RD: begin
            if (idx_ff == lim_ff) begin
               b_we = 1'b1;               // free the barrier
            end else begin
               w_re    = 1'b1;
               w_raddr = waddr(bar_ff, idx_ff);
            end
         end
         ST_REL_OUT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_data = '{client_id_res: wrd_ff.client,
                            stream_client_res: wrd_ff.stream,
                            result_code: code_ff, rejected: 1'b0,
                            last: (idx_nx == lim_ff)};
               m_we    = wrd_ff.stream && (int'(wrd_ff.client) < CLIENTS);
               m_waddr = CADDR_W'(wrd_ff.client);
               idx_in  = idx_nx;
            end
         end
         ST_MAP_RD: begin
            m_re = client_ok;
            m_we = client_ok;
         end
         ST_MAP_CHK: begin
            bar_in = mbb;
            lim_in = fill_ff[mbb];
            idx_in = '0;
         end
         ST_SRCH_RD: begin
            w_re    = 1'b1;
            w_raddr = waddr(bar_ff, idx_ff);
         end
         ST_SRCH_CHK: begin
            if (hit) begin
               // take back this waiter's contribution
               b_we       = 1'b1;
               b_valid_in = 1'b1;
               b_count_in = count_ff[bar_ff] - {wrd_ff.contrib[CONTRIB_W-1], wrd_ff.contrib};
               b_maxe_in  = maxe_ff[bar_ff];
               b_fill_in  = fill_ff[bar_ff];
            end else begin
               idx_in = idx_nx;
            end
         end
         ST_SH_RD: begin
            if (idx_nx >= lim_ff) begin
               b_we = 1'b1;
               if (lim_ff != FILL_W'(1)) begin
                  b_valid_in = 1'b1;
                  b_count_in = count_ff[bar_ff];
                  b_maxe_in  = maxe_ff[bar_ff];
                  b_fill_in  = lim_ff - FILL_W'(1);
               end
            end else begin
               w_re    = 1'b1;
               w_raddr = waddr(bar_ff, idx_nx);
            end
         end
         ST_SH_WR: begin
            w_we    = 1'b1;
            w_waddr = waddr(bar_ff, idx_ff);
            idx_in  = idx_nx;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MAP_INIT;
         init_ff  <= '0;
         for (int i = 0; i < BARRIERS; i++) begin
            valid_ff[i] <= 1'b0;
            count_ff[i] <= '0;
            maxe_ff[i]  <= '0;
            fill_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         if (b_we) begin
            valid_ff[b_wsel] <= b_valid_in;
            count_ff[b_wsel] <= b_count_in;
            maxe_ff[b_wsel]  <= b_maxe_in;
            fill_ff[b_wsel]  <= b_fill_in;
         end
      end
      if (q_pop) item_ff <= q_data;
      idx_ff  <= idx_in;
      lim_ff  <= lim_in;
      code_ff <= code_in;
      bar_ff  <= bar_in;
   end

   always_ff @(posedge clock) begin
      if (w_re) wrd_ff <= wmem[w_raddr];
      if (w_we) wmem[w_waddr] <= w_wdata;
   end

   always_ff @(posedge clock) begin
      if (m_re) mrd_ff <= mmem[m_raddr];
      if (m_we) mmem[m_waddr] <= m_wdata;
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full) else $error("result pushed into full queue");
   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP_INIT) |-> !q_pop) else $error("pop during map sweep");
   a_rel_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL_OUT) |-> (idx_ff < lim_ff)) else $error("release past fill");

endmodule
